@@ hw/rtl/crcfp_pkg.sv @@
// Shared types, constants and the CRC-16/CCITT-FALSE byte update for the frame parser.
`default_nettype none

package crcfp_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_ACCEPT  = 2'd1,
        KIND_REJECT  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_OK        = 3'd0,
        ERR_SHORT     = 3'd1,
        ERR_HEADER    = 3'd2,
        ERR_TYPE      = 3'd3,
        ERR_TOO_LARGE = 3'd4,
        ERR_CRC       = 3'd5
    } err_t;

    typedef struct packed {
        logic [15:0] header_word;
        logic [7:0]  type_request;
        logic [7:0]  type_response;
        logic [7:0]  type_event;
        logic [7:0]  type_status;
        logic [15:0] max_payload;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        logic [7:0]  dev;
        logic [7:0]  ftype;
        logic [7:0]  cmd;
        logic        is_status;
        logic [15:0] len;
        err_t        err;
    } rec_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/crcfp_front.sv @@
// Front end: accepts buffer bytes, tracks frame position and CRC, and classifies each byte.
`default_nettype none

module crcfp_front
    import crcfp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_t       cfg,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       start_req,
    input  wire logic       buf_end,
    output logic            push_valid,
    input  wire logic       push_ready,
    output rec_t            push_data
);

    logic [16:0] pos_reg, pos_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  hdr_high_reg, hdr_high_next;
    logic        header_bad_reg, header_bad_next;
    logic [7:0]  dev_reg, dev_next;
    logic [7:0]  ftype_reg, ftype_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [15:0] len_reg, len_next;
    logic [7:0]  rxh_reg, rxh_next;
    logic        done_reg, done_next;

    logic        in_fire;
    logic [16:0] p;
    logic [15:0] crc_cur;
    logic [15:0] crc_upd;
    logic [7:0]  hdr_eff, dev_eff, ftype_eff, cmd_eff, rxh_eff;
    logic        hb_eff, done_eff;
    logic [15:0] len_eff;
    logic [16:0] len_x;
    logic        stat;
    logic        type_known;
    logic        crc_ok;

    function automatic rec_t make_reject(input err_t code);
        rec_t r;
        r      = '0;
        r.kind = KIND_REJECT;
        r.err  = code;
        return r;
    endfunction

    assign in_ready = push_ready;
    assign in_fire  = in_valid && in_ready;

    assign p         = start_req ? 17'd0 : pos_reg;
    assign crc_cur   = start_req ? CRC_INIT : crc_reg;
    assign hdr_eff   = start_req ? 8'h00 : hdr_high_reg;
    assign hb_eff    = start_req ? 1'b0 : header_bad_reg;
    assign dev_eff   = start_req ? 8'h00 : dev_reg;
    assign ftype_eff = start_req ? 8'h00 : ftype_reg;
    assign cmd_eff   = start_req ? 8'h00 : cmd_reg;
    assign len_eff   = start_req ? 16'h0000 : len_reg;
    assign rxh_eff   = start_req ? 8'h00 : rxh_reg;
    assign done_eff  = start_req ? 1'b0 : done_reg;

    assign len_x      = {1'b0, len_eff};
    assign crc_upd    = crc16_byte(crc_cur, in_byte);
    assign stat       = (ftype_eff == cfg.type_status);
    assign type_known = (ftype_eff == cfg.type_request) || (ftype_eff == cfg.type_response)
                        || (ftype_eff == cfg.type_event);
    assign crc_ok     = ({rxh_eff, in_byte} == crc_cur);

    always_comb
    begin
        rec_t fin;
        fin           = '0;
        fin.kind      = KIND_ACCEPT;
        fin.dev       = dev_eff;
        fin.ftype     = ftype_eff;
        fin.cmd       = cmd_eff;
        fin.is_status = (p == 17'd7) && stat;
        fin.len       = len_eff;
        fin.err       = ERR_OK;
        if (!crc_ok)
        begin
            fin = make_reject(ERR_CRC);
        end

        pos_next        = pos_reg;
        crc_next        = crc_reg;
        hdr_high_next   = hdr_high_reg;
        header_bad_next = header_bad_reg;
        dev_next        = dev_reg;
        ftype_next      = ftype_reg;
        cmd_next        = cmd_reg;
        len_next        = len_reg;
        rxh_next        = rxh_reg;
        done_next       = done_reg;
        push_valid      = 1'b0;
        push_data       = '0;

        if (in_fire)
        begin
            pos_next        = p;
            crc_next        = crc_cur;
            hdr_high_next   = hdr_eff;
            header_bad_next = hb_eff;
            dev_next        = dev_eff;
            ftype_next      = ftype_eff;
            cmd_next        = cmd_eff;
            len_next        = len_eff;
            rxh_next        = rxh_eff;
            done_next       = done_eff;

            if (!done_eff)
            begin
                if (p < 17'd7)
                begin
                    unique case (p[2:0])
                        3'd0: hdr_high_next = in_byte;
                        3'd1: header_bad_next = ({hdr_eff, in_byte} != cfg.header_word);
                        3'd2: dev_next = in_byte;
                        3'd3: ftype_next = in_byte;
                        3'd4: cmd_next = in_byte;
                        3'd5: len_next = {8'h00, in_byte};
                        default:
                        begin
                            if (stat)
                            begin
                                rxh_next = in_byte;
                            end
                            else
                            begin
                                len_next = {len_eff[7:0], in_byte};
                            end
                        end
                    endcase
                    if (p >= 17'd2 && (p <= 17'd5 || (p == 17'd6 && !stat)))
                    begin
                        crc_next = crc_upd;
                    end
                    if (buf_end)
                    begin
                        push_valid = 1'b1;
                        push_data  = make_reject(ERR_SHORT);
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        pos_next = p + 17'd1;
                    end
                end
                else
                begin
                    priority if (p == 17'd7 && hb_eff)
                    begin
                        push_valid = 1'b1;
                        push_data  = make_reject(ERR_HEADER);
                        done_next  = 1'b1;
                    end
                    else if (p == 17'd7 && stat)
                    begin
                        push_valid = 1'b1;
                        push_data  = fin;
                        done_next  = 1'b1;
                    end
                    else if (p == 17'd7 && !type_known)
                    begin
                        push_valid = 1'b1;
                        push_data  = make_reject(ERR_TYPE);
                        done_next  = 1'b1;
                    end
                    else if (p == 17'd7 && len_eff > cfg.max_payload)
                    begin
                        push_valid = 1'b1;
                        push_data  = make_reject(ERR_TOO_LARGE);
                        done_next  = 1'b1;
                    end
                    else if (p >= len_x + 17'd8)
                    begin
                        push_valid = 1'b1;
                        push_data  = fin;
                        done_next  = 1'b1;
                    end
                    else if (buf_end)
                    begin
                        push_valid = 1'b1;
                        push_data  = make_reject(ERR_SHORT);
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        pos_next = p + 17'd1;
                        if (p <= len_x + 17'd6)
                        begin
                            crc_next       = crc_upd;
                            push_valid     = 1'b1;
                            push_data.kind = KIND_PAYLOAD;
                            push_data.data = in_byte;
                        end
                        else
                        begin
                            rxh_next = in_byte;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            crc_reg        <= CRC_INIT;
            hdr_high_reg   <= '0;
            header_bad_reg <= 1'b0;
            dev_reg        <= '0;
            ftype_reg      <= '0;
            cmd_reg        <= '0;
            len_reg        <= '0;
            rxh_reg        <= '0;
            done_reg       <= 1'b1;
        end
        else
        begin
            pos_reg        <= pos_next;
            crc_reg        <= crc_next;
            hdr_high_reg   <= hdr_high_next;
            header_bad_reg <= header_bad_next;
            dev_reg        <= dev_next;
            ftype_reg      <= ftype_next;
            cmd_reg        <= cmd_next;
            len_reg        <= len_next;
            rxh_reg        <= rxh_next;
            done_reg       <= done_next;
        end
    end

    a_push_needs_input: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> in_fire)
        else $error("result pushed without an input transaction");

    a_verdict_closes: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid && push_data.kind != KIND_PAYLOAD |=> done_reg)
        else $error("verdict did not close the frame");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && !(in_valid && start_req) |=> done_reg)
        else $error("parser left idle without a start");

    a_payload_position: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid && push_data.kind == KIND_PAYLOAD |-> !start_req && pos_reg >= 17'd7)
        else $error("payload byte before the length field");

endmodule

`default_nettype wire

@@ hw/rtl/crcfp_queue.sv @@
// Short result queue between the parser front end and the output stage.
`default_nettype none

module crcfp_queue
    import crcfp_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire rec_t push_data,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output rec_t      pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    rec_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push_fire, pop_fire;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop_fire && !push_fire)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/crcfp_back.sv @@
// Output stage: expands queued results into the result fields and holds them for the consumer.
`default_nettype none

module crcfp_back
    import crcfp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic pop_valid,
    output logic      pop_ready,
    input  wire rec_t pop_data,
    output logic        out_valid,
    input  wire logic   out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  payload_byte,
    output logic [7:0]  node_id,
    output logic [7:0]  type_code,
    output logic [7:0]  command,
    output logic        is_status,
    output logic [7:0]  status_code,
    output logic [15:0] body_len,
    output logic [16:0] total_len,
    output logic [2:0]  error_code
);

    logic        valid_reg, valid_next;
    kind_t       kind_reg, kind_next;
    logic [7:0]  pbyte_reg, pbyte_next;
    logic [7:0]  dev_reg, dev_next;
    logic [7:0]  ftype_reg, ftype_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic        stat_reg, stat_next;
    logic [7:0]  scode_reg, scode_next;
    logic [15:0] plen_reg, plen_next;
    logic [16:0] flen_reg, flen_next;
    err_t        err_reg, err_next;
    logic        load;

    assign pop_ready = !valid_reg || out_ready;
    assign load      = pop_valid && pop_ready;

    always_comb
    begin
        valid_next = valid_reg;
        kind_next  = kind_reg;
        pbyte_next = pbyte_reg;
        dev_next   = dev_reg;
        ftype_next = ftype_reg;
        cmd_next   = cmd_reg;
        stat_next  = stat_reg;
        scode_next = scode_reg;
        plen_next  = plen_reg;
        flen_next  = flen_reg;
        err_next   = err_reg;
        if (valid_reg && out_ready)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            valid_next = 1'b1;
            kind_next  = pop_data.kind;
            pbyte_next = '0;
            dev_next   = '0;
            ftype_next = '0;
            cmd_next   = '0;
            stat_next  = 1'b0;
            scode_next = '0;
            plen_next  = '0;
            flen_next  = '0;
            err_next   = ERR_OK;
            unique case (pop_data.kind)
                KIND_PAYLOAD:
                begin
                    pbyte_next = pop_data.data;
                end
                KIND_ACCEPT:
                begin
                    dev_next   = pop_data.dev;
                    ftype_next = pop_data.ftype;
                    cmd_next   = pop_data.cmd;
                    stat_next  = pop_data.is_status;
                    if (pop_data.is_status)
                    begin
                        scode_next = pop_data.len[7:0];
                        flen_next  = 17'd8;
                    end
                    else
                    begin
                        plen_next = pop_data.len;
                        flen_next = {1'b0, pop_data.len} + 17'd9;
                    end
                end
                default:
                begin
                    err_next = pop_data.err;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        pbyte_reg <= pbyte_next;
        dev_reg   <= dev_next;
        ftype_reg <= ftype_next;
        cmd_reg   <= cmd_next;
        stat_reg  <= stat_next;
        scode_reg <= scode_next;
        plen_reg  <= plen_next;
        flen_reg  <= flen_next;
        err_reg   <= err_next;
    end

    assign out_valid    = valid_reg;
    assign kind         = kind_reg;
    assign payload_byte = pbyte_reg;
    assign node_id      = dev_reg;
    assign type_code    = ftype_reg;
    assign command      = cmd_reg;
    assign is_status    = stat_reg;
    assign status_code  = scode_reg;
    assign body_len     = plen_reg;
    assign total_len    = flen_reg;
    assign error_code   = err_reg;

endmodule

`default_nettype wire

@@ hw/rtl/crc16_frame_parser.sv @@
// Top level of the CRC-16 framed packet parser: config registers, front end, queue, output.
// Path: a result passes through the result queue and then the output register before it
//   is presented on the outputs.
// Throughput: one byte per cycle; the front end's 8-bit CRC update is combinational;
//   input keeps flowing while results wait, until the result queue and output register fill.
// Reset: parser idles and ignores bytes until a byte with start_req; configuration
//   registers return to their defaults; queue and output register empty.
`default_nettype none

module crc16_frame_parser
    import crcfp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    input  wire logic        start_req,
    input  wire logic        buf_end,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic [7:0]       payload_byte,
    output logic [7:0]       node_id,
    output logic [7:0]       type_code,
    output logic [7:0]       command,
    output logic             is_status,
    output logic [7:0]       status_code,
    output logic [15:0]      body_len,
    output logic [16:0]      total_len,
    output logic [2:0]       error_code
);

    localparam logic [2:0] REG_HEADER_WORD   = 3'd0;
    localparam logic [2:0] REG_TYPE_REQUEST  = 3'd1;
    localparam logic [2:0] REG_TYPE_RESPONSE = 3'd2;
    localparam logic [2:0] REG_TYPE_EVENT    = 3'd3;
    localparam logic [2:0] REG_TYPE_STATUS   = 3'd4;
    localparam logic [2:0] REG_MAX_PAYLOAD   = 3'd5;

    cfg_t cfg_reg, cfg_next;
    logic push_valid, push_ready;
    rec_t push_data;
    logic pop_valid, pop_ready;
    rec_t pop_data;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_HEADER_WORD:   cfg_next.header_word   = cfg_data;
                REG_TYPE_REQUEST:  cfg_next.type_request  = cfg_data[7:0];
                REG_TYPE_RESPONSE: cfg_next.type_response = cfg_data[7:0];
                REG_TYPE_EVENT:    cfg_next.type_event    = cfg_data[7:0];
                REG_TYPE_STATUS:   cfg_next.type_status   = cfg_data[7:0];
                REG_MAX_PAYLOAD:   cfg_next.max_payload   = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_word   <= 16'hAA55;
            cfg_reg.type_request  <= 8'd1;
            cfg_reg.type_response <= 8'd2;
            cfg_reg.type_event    <= 8'd3;
            cfg_reg.type_status   <= 8'd4;
            cfg_reg.max_payload   <= 16'd256;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    crcfp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .start_req  (start_req),
        .buf_end    (buf_end),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    crcfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    crcfp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_data     (pop_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .payload_byte (payload_byte),
        .node_id      (node_id),
        .type_code    (type_code),
        .command      (command),
        .is_status    (is_status),
        .status_code  (status_code),
        .body_len     (body_len),
        .total_len    (total_len),
        .error_code   (error_code)
    );

endmodule

`default_nettype wire
